/* design/table_linear_interpolator_defines.svh */
// Assertion macros shared by the interpolator RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that holds outside of reset.
`define TLI_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);
// Check that holds at every edge, reset included.
`define TLI_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) expr) else $error(msg);
`else
`define TLI_ASSERT(label, expr, msg)
`define TLI_ASSERT_ALWAYS(label, expr, msg)
`endif

`endif

/* design/tli_pkg.sv */
package tli_pkg;

  // Default table depth.
  localparam int DEPTH_DEFAULT = 128;

  // Field widths.
  localparam int IDX_W = 7;
  localparam int X_W   = 16;
  localparam int Y_W   = 32;
  localparam int PIU_W = 8;

  // Reset value of the active point count register.
  localparam logic [PIU_W-1:0] PIU_RESET = 8'd128;

  // Magnitude of (q - x0) * (y1 - y0) always fits in this many bits.
  localparam int NUM_W = 48;

  // Input item kinds carried in tuser.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // One table point.
  typedef struct packed {
    logic signed [Y_W-1:0] y;
    logic        [X_W-1:0] x;
  } tli_entry_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [X_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/tli_table.sv */
module tli_table
  import tli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tli_entry_t    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output tli_entry_t    rdata
);

  tli_entry_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tli_divider.sv */
module tli_divider
  import tli_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [X_W-1:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [X_W-1:0]   divisor;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [X_W:0]     rem_sh;
  logic [X_W:0]     trial;
  logic             fits;

  // One restoring step: bring in the next dividend bit and try the subtract.
  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    trial  = rem_sh - {1'b0, divisor};
    fits   = (rem_sh >= {1'b0, divisor});
  end

  // Control: a run takes one step per cycle over all dividend bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: the dividend shifts out while the quotient shifts in.
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
      cnt     <= CNT_W'(NUM_W - 1);
    end else if (busy) begin
      rem <= fits ? trial[X_W-1:0] : rem_sh[X_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* design/table_linear_interpolator.sv */
// Piecewise linear interpolation over a table of (x, y) points.
// Slave channel: s_tuser selects the kind of transaction (0 = load a point,
// 1 = query). A load writes one point and gives no result.
// A query scans the first points_in_use entries, clamped to the range two
// to the table depth, one per cycle through the table memory read port, for
// an exact match or the first point above the query. An exact hit returns
// the stored y; a query outside the table returns zero with out_of_range
// set. Otherwise the block forms (q - x0) * (y1 - y0) in one multiply and
// divides it by (x1 - x0) in a bit-serial divider of 48 steps, truncating
// toward zero. A match ends the scan early.
// s_tready is high only while no query is in progress, so a new query
// waits for the last one to finish; a load leaves the block ready for the
// next item. The result sits in an output register: a new query may be
// accepted while it waits, and a finished query holds until the receiver
// takes the old one. Reset (rst, synchronous) clears the handshake state
// and sets points_in_use to 128; the table is not cleared and must be
// loaded first.
`include "table_linear_interpolator_defines.svh"

module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: points_in_use.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // point_index[6:0], x_value[22:7], y_value[54:23], zero
  input  logic        s_tuser,   // mode
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // y_result[31:0]
  output logic [1:0]  m_tuser    // exact_hit[0], out_of_range[1]
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_DIFF = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_DIVS = 8'b0001_0000,
    ST_DIVW = 8'b0010_0000,
    ST_ADD  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state;

  // Unpacked input fields.
  logic [IDX_W-1:0]      in_index;
  logic [X_W-1:0]        in_x;
  logic signed [Y_W-1:0] in_y;
  logic                  in_mode;

  assign in_index = s_tdata[6:0];
  assign in_x     = s_tdata[22:7];
  assign in_y     = s_tdata[54:23];
  assign in_mode  = s_tuser;

  logic [PIU_W-1:0] points_in_use;

  // Query registers.
  logic [X_W-1:0]        q;
  logic [CW-1:0]         n_act;
  logic [CW-1:0]         issue_idx;
  logic                  pend;
  logic [CW-1:0]         pend_idx;
  logic                  found;
  logic                  above_zero;
  logic [X_W-1:0]        x0;
  logic [X_W-1:0]        x1;
  logic signed [Y_W-1:0] y0;
  logic signed [Y_W-1:0] y1;
  logic [X_W-1:0]        prev_x;
  logic signed [Y_W-1:0] prev_y;
  logic [X_W-1:0]        dq;
  logic [X_W-1:0]        dx;
  logic signed [Y_W:0]   dy;
  logic signed [49:0]    prod;
  logic                  neg;
  logic [Y_W-1:0]        res;
  logic                  res_hit;
  logic                  res_oor;

  // Table memory signals.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  tli_entry_t    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  tli_entry_t    mem_rdata;

  // Divider signals.
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Helper values.
  logic [31:0]  idx32;
  logic [31:0]  piu32;
  logic [31:0]  cnt32;
  logic         in_fire;
  logic         issue_ok;
  logic         last_eval;
  logic         found_now;
  logic         az_now;
  logic [49:0]  mag;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // Load address and bound check.
  assign idx32     = 32'(in_index);
  assign mem_we    = in_fire && (in_mode == MODE_LOAD) && (idx32 < DEPTH32);
  assign mem_waddr = idx32[AW-1:0];
  assign mem_wdata = '{y: in_y, x: in_x};

  // Active count clamped to the range two to the table depth.
  always_comb begin
    piu32 = 32'(points_in_use);
    if (piu32 < 32'd2) begin
      cnt32 = 32'd2;
    end else if (piu32 > DEPTH32) begin
      cnt32 = DEPTH32;
    end else begin
      cnt32 = piu32;
    end
  end

  // Scan reads one entry per cycle.
  assign issue_ok  = (state == ST_SCAN) && (issue_idx < n_act);
  assign mem_re    = issue_ok;
  assign mem_raddr = issue_idx[AW-1:0];

  // Scan decisions on the entry just read.
  assign last_eval = pend && (pend_idx == n_act - CW'(1));
  assign found_now = found || (mem_rdata.x > q);
  assign az_now    = found ? above_zero : (pend_idx == '0);

  // Sign and magnitude of the product for the unsigned divider.
  assign mag = prod[49] ? 50'(-prod) : 50'(prod);

  assign div_req.start    = (state == ST_DIVS);
  assign div_req.dividend = mag[NUM_W-1:0];
  assign div_req.divisor  = dx;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= PIU_RESET;
    end else if (cfg_we) begin
      points_in_use <= cfg_wdata;
    end
  end

  // Sequencer and result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
    end else begin
      // The result register fills from ST_DONE and empties on a handshake.
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && in_mode == MODE_QUERY) begin
            state <= ST_SCAN;
            pend  <= 1'b0;
          end
        end
        ST_SCAN: begin
          pend <= issue_ok;
          if (pend && mem_rdata.x == q) begin
            state <= ST_DONE;
          end else if (last_eval) begin
            state <= (!found_now || az_now) ? ST_DONE : ST_DIFF;
          end
        end
        ST_DIFF: state <= ST_MUL;
        ST_MUL:  state <= ST_DIVS;
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_rsp.done) begin
            state <= ST_ADD;
          end
        end
        ST_ADD:  state <= ST_DONE;
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q         <= in_x;
        n_act     <= cnt32[CW-1:0];
        issue_idx <= '0;
        found     <= 1'b0;
      end
      ST_SCAN: begin
        if (issue_ok) begin
          issue_idx <= issue_idx + CW'(1);
          pend_idx  <= issue_idx;
        end
        if (pend) begin
          if (mem_rdata.x == q) begin
            res     <= mem_rdata.y;
            res_hit <= 1'b1;
            res_oor <= 1'b0;
          end else begin
            if (!found && mem_rdata.x > q) begin
              found      <= 1'b1;
              above_zero <= (pend_idx == '0);
              x1         <= mem_rdata.x;
              y1         <= mem_rdata.y;
              x0         <= prev_x;
              y0         <= prev_y;
            end
            prev_x <= mem_rdata.x;
            prev_y <= mem_rdata.y;
            if (last_eval) begin
              res     <= '0;
              res_hit <= 1'b0;
              res_oor <= !found_now || az_now;
            end
          end
        end
      end
      ST_DIFF: begin
        dq <= q - x0;
        dx <= x1 - x0;
        dy <= {y1[Y_W-1], y1} - {y0[Y_W-1], y0};
      end
      ST_MUL: begin
        prod <= $signed({1'b0, dq}) * dy;
      end
      ST_DIVS: begin
        neg <= prod[49];
      end
      ST_ADD: begin
        res     <= neg ? (y0 - div_rsp.quotient[Y_W-1:0])
                       : (y0 + div_rsp.quotient[Y_W-1:0]);
        res_hit <= 1'b0;
        res_oor <= 1'b0;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= res;
          m_tuser <= {res_oor, res_hit};
        end
      end
      default: begin
      end
    endcase
  end

  tli_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tli_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A result is never both an exact hit and out of range.
  `TLI_ASSERT(a_flags_exclusive, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "hit and range flags both set")
  // An out-of-range result carries zero.
  `TLI_ASSERT(a_oor_zero, (m_tvalid && m_tuser[1]) |-> (m_tdata == 32'd0), "out-of-range result not zero")
  // A load leaves the block ready for the next transaction.
  `TLI_ASSERT(a_load_one_cycle, (in_fire && !s_tuser) |=> s_tready, "load did not finish in one cycle")
  // A query holds off the input channel while it is worked on.
  `TLI_ASSERT(a_query_busy, (in_fire && s_tuser) |=> !s_tready, "input ready during a query")
  // The divider is only started while idle.
  `TLI_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider started while busy")

endmodule

/* bench/table_linear_interpolator_test.sv */
module table_linear_interpolator_test;
  import tli_pkg::*;

  localparam int ITEM_TARGET   = 1150;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_TAIL      = 256;
  localparam int MAX_WAIT      = 12;

  // One expected lookup result, tagged with the query that caused it.
  typedef struct {
    logic [X_W-1:0]        query;
    logic signed [Y_W-1:0] y;
    logic                  hit;
    logic                  oor;
  } lookup_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [PIU_W-1:0] cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [55:0]      s_tdata;   // point_index[6:0], x_value[22:7], y_value[54:23], zero
  logic             s_tuser;   // mode
  logic             m_tvalid;
  logic             m_tready;
  logic [31:0]      m_tdata;   // y_result[31:0]
  logic [1:0]       m_tuser;   // exact_hit[0], out_of_range[1]

  // Shadow copy of the point table and the active point count.
  logic [X_W-1:0]        table_x [DEPTH_DEFAULT];
  logic signed [Y_W-1:0] table_y [DEPTH_DEFAULT];
  logic [PIU_W-1:0]      active_points;

  lookup_t lookup_queue [$];
  int      error_count = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  bit      idle_off = 1'b0;
  int      stall_left = 0;
  bit      stall_on_valid = 1'b0;

  table_linear_interpolator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Free-running clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter and the run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL table_linear_interpolator");
    $finish;
  end

  // Number of idle cycles before the next transaction on either side.
  function automatic int draw_wait();
    if (idle_off) begin
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Expected result of a query against the shadow table.
  function automatic lookup_t interpolate_point(input logic [X_W-1:0] q);
    lookup_t r;
    int      n;
    int      above;
    longint  x0;
    longint  x1;
    longint  y0;
    longint  y1;
    r.query = q;
    r.y = '0;
    r.hit = 1'b0;
    r.oor = 1'b0;
    n = active_points;
    if (n < 2) begin
      n = 2;
    end
    if (n > DEPTH_DEFAULT) begin
      n = DEPTH_DEFAULT;
    end
    // The first stored abscissa equal to the query wins.
    for (int i = 0; i < n; i++) begin
      if (table_x[i] == q) begin
        r.y = table_y[i];
        r.hit = 1'b1;
        return r;
      end
    end
    // Otherwise interpolate below the first point above the query.
    above = -1;
    for (int i = 0; i < n; i++) begin
      if (table_x[i] > q) begin
        above = i;
        break;
      end
    end
    if (above <= 0) begin
      r.oor = 1'b1;
      return r;
    end
    x0 = table_x[above-1];
    x1 = table_x[above];
    y0 = table_y[above-1];
    y1 = table_y[above];
    // Signed 64-bit division truncates toward zero.
    r.y = Y_W'(y0 + ((longint'(q) - x0) * (y1 - y0)) / (x1 - x0));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    error_count++;
  endtask

  // Sends one transaction and updates the shadow state when it is accepted.
  task automatic send_item(input logic mode, input logic [IDX_W-1:0] slot,
                           input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {1'b0, y, x, slot};
    do @(posedge clk); while (!s_tready);
    if (mode == MODE_LOAD) begin
      table_x[slot] = x;
      table_y[slot] = y;
    end else begin
      lookup_queue.push_back(interpolate_point(x));
    end
    items_sent++;
  endtask

  // Queries carry random point_index and y_value, which the block ignores.
  task automatic send_query(input logic [X_W-1:0] q);
    send_item(MODE_QUERY, IDX_W'($urandom), q, Y_W'($urandom));
  endtask

  // Stops sending and waits for every pending result, then for the given extra cycles.
  task automatic settle_block(input int extra);
    s_tvalid <= 1'b0;
    while (lookup_queue.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Writes points_in_use once the block has gone idle.
  task automatic write_points(input logic [PIU_W-1:0] value);
    settle_block(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_points = value;
  endtask

  function automatic logic [Y_W-1:0] random_y();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return Y_W'($urandom);
    endcase
  endfunction

  // Loads slots 0 to k-1 with strictly ascending x, in shuffled order.
  task automatic load_sorted_table(input int k);
    logic [X_W-1:0] xv [DEPTH_DEFAULT];
    int             order [DEPTH_DEFAULT];
    int             step_max;
    int             xs;
    int             j;
    int             tmp;
    step_max = ($urandom_range(0, 3) == 0) ? 3 : 65000 / k;
    xs = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
    for (int i = 0; i < k; i++) begin
      xv[i] = X_W'(xs);
      xs += $urandom_range(1, step_max);
      order[i] = i;
    end
    for (int i = k - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < k; i++) begin
      send_item(MODE_LOAD, IDX_W'(order[i]), xv[order[i]], random_y());
    end
  endtask

  // Picks a query that lands on a point, between points, or outside the table.
  function automatic logic [X_W-1:0] pick_query(input int k);
    int i;
    int lo;
    int hi;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        return table_x[$urandom_range(0, k - 1)];
      end
      3, 4, 5, 6: begin
        i = $urandom_range(0, k - 2);
        lo = table_x[i];
        hi = table_x[i+1];
        if (hi - lo > 1) begin
          return X_W'(lo + $urandom_range(1, hi - lo - 1));
        end
        return X_W'(lo);
      end
      7: begin
        lo = table_x[0];
        if (lo > 0) begin
          return X_W'($urandom_range(0, lo - 1));
        end
        return '0;
      end
      8: begin
        hi = table_x[k-1];
        if (hi < 65535) begin
          return X_W'($urandom_range(hi + 1, 65535));
        end
        return '1;
      end
      default: begin
        return X_W'($urandom);
      end
    endcase
  endfunction

  // Two points at the extremes of the y axis, queried at every edge of the x range.
  task automatic test_two_point_extremes();
    write_points(8'd0);
    send_item(MODE_LOAD, 7'd0, 16'h0100, 32'h8000_0000);
    send_item(MODE_LOAD, 7'd1, 16'hFF00, 32'h7FFF_FFFF);
    send_query(16'h0000);
    send_query(16'h00FF);
    send_query(16'h0100);
    send_query(16'hFF00);
    send_query(16'hFF01);
    send_query(16'hFFFF);
    send_query(16'h8080);
    send_query(16'h0101);
  endtask

  // Falling slopes and quotients that must truncate toward zero.
  task automatic test_slope_truncation();
    write_points(8'd1);
    send_item(MODE_LOAD, 7'd0, 16'h0000, 32'h7FFF_FFFF);
    send_item(MODE_LOAD, 7'd1, 16'hFFFF, 32'h8000_0000);
    send_query(16'h0001);
    send_item(MODE_QUERY, 7'h7F, 16'h7FFF, 32'hFFFF_FFFF);
    send_query(16'hFFFE);
    send_item(MODE_LOAD, 7'd0, 16'h0010, 32'h0000_0000);
    send_item(MODE_LOAD, 7'd1, 16'h0013, 32'hFFFF_FFFF);
    send_query(16'h0011);
    send_query(16'h0012);
  endtask

  // Out-of-order points and a duplicated abscissa.
  task automatic test_unsorted_table();
    send_item(MODE_LOAD, 7'd0, 16'h9000, 32'h0064_0000);
    send_item(MODE_LOAD, 7'd1, 16'h1000, 32'hFF9C_8000);
    send_item(MODE_LOAD, 7'd2, 16'hF000, 32'h0003_0001);
    write_points(8'd3);
    send_query(16'h0800);
    send_query(16'h5000);
    send_query(16'hA000);
    send_query(16'h1000);
    send_query(16'hF800);
    send_item(MODE_LOAD, 7'd2, 16'h9000, 32'h1234_5678);
    send_query(16'h9000);
  endtask

  // A full table with point counts at and beyond the depth.
  task automatic test_count_clamp();
    load_sorted_table(DEPTH_DEFAULT);
    write_points(8'd255);
    send_query(table_x[DEPTH_DEFAULT-1]);
    repeat (5) send_query(pick_query(DEPTH_DEFAULT));
    write_points(8'd200);
    repeat (4) send_query(pick_query(DEPTH_DEFAULT));
    write_points(8'd128);
    repeat (4) send_query(pick_query(DEPTH_DEFAULT));
  endtask

  // Mostly freshly sorted tables of random size, with bursts of stray loads
  // and queries in between.
  task automatic test_random_tables();
    int k;
    int count;
    int cfg;
    while (items_sent < ITEM_TARGET) begin
      idle_off = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) != 0) begin
          k = $urandom_range(2, 12);
        end else begin
          k = $urandom_range(13, DEPTH_DEFAULT);
        end
        load_sorted_table(k);
        if (k == 2) begin
          cfg = $urandom_range(0, 2);
        end else if (k == DEPTH_DEFAULT) begin
          cfg = $urandom_range(DEPTH_DEFAULT, 255);
        end else begin
          cfg = k;
        end
        write_points(PIU_W'(cfg));
        count = $urandom_range(3, 12);
        repeat (count) send_query(pick_query(k));
      end else begin
        count = $urandom_range(5, 20);
        repeat (count) begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(MODE_LOAD, IDX_W'($urandom), X_W'($urandom), random_y());
          end else begin
            send_query(X_W'($urandom));
          end
        end
      end
    end
    idle_off = 1'b0;
  endtask

  // Result checker and receiver pacing. A stall is drawn after each result
  // and counts either at once or only while a result is waiting.
  always @(posedge clk) begin : result_check
    lookup_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lookup_queue.size() == 0) begin
        report_mismatch($sformatf("result with no query pending: y=%h flags=%b",
                                  m_tdata, m_tuser));
      end else begin
        want = lookup_queue.pop_front();
        if (m_tdata !== want.y) begin
          report_mismatch($sformatf("query %h: y_result %h, expected %h",
                                    want.query, m_tdata, want.y));
        end
        if (m_tuser[0] !== want.hit) begin
          report_mismatch($sformatf("query %h: exact_hit %b, expected %b",
                                    want.query, m_tuser[0], want.hit));
        end
        if (m_tuser[1] !== want.oor) begin
          report_mismatch($sformatf("query %h: out_of_range %b, expected %b",
                                    want.query, m_tuser[1], want.oor));
        end
      end
      stall_left = draw_wait();
      stall_on_valid = ($urandom_range(0, 1) == 1);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
      end
    end else if (!m_tready) begin
      if (!stall_on_valid || m_tvalid) begin
        stall_left--;
      end
      if (stall_left <= 0) begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= MODE_LOAD;
    m_tready  <= 1'b1;
    active_points = PIU_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_two_point_extremes();
    test_slope_truncation();
    test_unsorted_table();
    test_count_clamp();
    test_random_tables();

    settle_block(END_TAIL);
    if (error_count == 0) begin
      $display("PASS table_linear_interpolator");
    end else begin
      $display("FAIL table_linear_interpolator");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/tli_pkg.sv
design/tli_table.sv
design/tli_divider.sv
design/table_linear_interpolator.sv
bench/table_linear_interpolator_test.sv
